### rtl/reb_pkg.sv
`default_nettype none

package reb_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebW      = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;
  localparam logic [DebW-1:0] DebounceReset = 16'd40;
  localparam logic signed [3:0] DetentSteps = 4'sd4;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_CW   = 3'd1,
    EV_CCW  = 3'd2,
    EV_PUSH = 3'd3,
    EV_BACK = 3'd4
  } event_e;

  // per-beat control shared by the state-holding units
  typedef struct packed {
    logic adv;
    logic first;
  } step_ctrl_t;

  // index is {previous a, previous b, a, b}
  function automatic logic signed [1:0] move_step(logic [3:0] idx);
    logic signed [1:0] mv;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: mv = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: mv = 2'sd1;
      default: mv = 2'sd0;
    endcase
    return mv;
  endfunction

endpackage

`default_nettype wire

### rtl/reb_quad.sv
`default_nettype none

module reb_quad (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire reb_pkg::step_ctrl_t ctrl_i,
  input  wire logic [1:0]          ab_i,
  output reb_pkg::event_e          detent_o
);

  logic [1:0]        last_ab_q, last_ab_d;
  logic signed [3:0] sum_q, sum_d;
  logic signed [1:0] mv;
  logic signed [3:0] sum_new;

  always_comb begin
    mv       = reb_pkg::move_step({last_ab_q, ab_i});
    sum_new  = sum_q + {{2{mv[1]}}, mv};
    last_ab_d = last_ab_q;
    sum_d     = sum_q;
    detent_o  = reb_pkg::EV_NONE;
    if (ctrl_i.adv) begin
      last_ab_d = ab_i;
      if (ctrl_i.first) begin
        sum_d = sum_q;
      end else if (sum_new >= reb_pkg::DetentSteps) begin
        sum_d    = 4'sd0;
        detent_o = reb_pkg::EV_CW;
      end else if (sum_new <= -reb_pkg::DetentSteps) begin
        sum_d    = 4'sd0;
        detent_o = reb_pkg::EV_CCW;
      end else begin
        sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ab_q <= 2'b00;
      sum_q     <= 4'sd0;
    end else begin
      last_ab_q <= last_ab_d;
      sum_q     <= sum_d;
    end
  end

  // a full detent always clears, so the stored sum stays within three steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q != 4'sd4) && (sum_q != -4'sd4))
    else $error("step sum left holding a full detent");

endmodule

`default_nettype wire

### rtl/reb_debounce.sv
`default_nettype none

module reb_debounce (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire reb_pkg::step_ctrl_t            ctrl_i,
  input  wire logic                           inhibit_i,
  input  wire logic                           level_i,
  input  wire logic [reb_pkg::TimeW-1:0]      now_i,
  input  wire logic [reb_pkg::DebW-1:0]       debounce_i,
  output logic                                rise_o
);

  logic                      raw_q, raw_d;
  logic                      stable_q, stable_d;
  logic [reb_pkg::TimeW-1:0] chg_q, chg_d, chg_new, elapsed;
  logic                      held, settle;

  always_comb begin
    chg_new  = (level_i != raw_q) ? now_i : chg_q;
    elapsed  = now_i - chg_new;
    held     = elapsed >= {{(reb_pkg::TimeW - reb_pkg::DebW){1'b0}}, debounce_i};
    settle   = !ctrl_i.first && (level_i != stable_q) && held;
    rise_o   = settle && level_i && !inhibit_i;
    raw_d    = raw_q;
    stable_d = stable_q;
    chg_d    = chg_q;
    if (ctrl_i.adv) begin
      raw_d = level_i;
      chg_d = chg_new;
      if (ctrl_i.first) begin
        stable_d = level_i;
        chg_d    = now_i;
      end else if (settle && !inhibit_i) begin
        stable_d = level_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      chg_q    <= '0;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      chg_q    <= chg_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.adv && ctrl_i.first |=> (stable_q == raw_q) && (chg_q == $past(now_i)))
    else $error("first sample did not load button state");

endmodule

`default_nettype wire

### rtl/rotary_encoder_button_qualifier.sv
// an accepted beat is held in the input register, then its event is registered in the result register for m_axis
// throughput: one sample per cycle while m_axis is not stalled, state feedback closes within the single logic stage
// the input register and result register each take a beat while the next stage frees
// reset: asynchronous, active low; clears all decoder and button state, debounce to 40 ms
// the first sample after reset only loads the state and yields no event
`default_nettype none

module rotary_encoder_button_qualifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rotary_a, rotary_b, push_level, back_level, now_ms[31:0], zero pad
  input  wire logic [reb_pkg::InDataW-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // event_res[2:0], zero pad
  output logic [reb_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [reb_pkg::DebW-1:0]    deb_q;
  logic                        in_vld_q, in_vld_d;
  logic [reb_pkg::InDataW-1:0] in_data_q;
  logic                        out_vld_q, out_vld_d;
  reb_pkg::event_e             out_evt_q, evt_d;
  logic                        started_q;
  logic                        out_free, adv, in_acc;
  reb_pkg::step_ctrl_t         ctrl;
  reb_pkg::event_e             detent;
  logic                        push_rise, back_rise;
  logic [reb_pkg::TimeW-1:0]   now;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ctrl          = '{adv: adv, first: !started_q};
  assign now           = in_data_q[4 +: reb_pkg::TimeW];

  reb_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .ab_i     ({in_data_q[0], in_data_q[1]}),
    .detent_o (detent)
  );

  reb_debounce u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .inhibit_i  (1'b0),
    .level_i    (in_data_q[3]),
    .now_i      (now),
    .debounce_i (deb_q),
    .rise_o     (back_rise)
  );

  // a back event skips the push check for this sample
  reb_debounce u_push (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .inhibit_i  (back_rise),
    .level_i    (in_data_q[2]),
    .now_i      (now),
    .debounce_i (deb_q),
    .rise_o     (push_rise)
  );

  always_comb begin
    priority if (back_rise) begin
      evt_d = reb_pkg::EV_BACK;
    end else if (push_rise) begin
      evt_d = reb_pkg::EV_PUSH;
    end else begin
      evt_d = detent;
    end
    in_vld_d  = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
    out_vld_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= reb_pkg::DebounceReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        deb_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_data_q <= s_axis_tdata;
    end
    if (adv) begin
      out_evt_q <= evt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(reb_pkg::OutDataW - 3){1'b0}}, out_evt_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !started_q |=> started_q && (out_evt_q == reb_pkg::EV_NONE))
    else $error("first sample produced an event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !started_q |-> !back_rise && !push_rise && (detent == reb_pkg::EV_NONE))
    else $error("event source active on the loading sample");

  // a stalled result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

endmodule

`default_nettype wire

### tb/tb_rotary_encoder_button_qualifier.sv
`timescale 1ns / 100ps

module tb_rotary_encoder_button_qualifier;

  // quadrature positions in clockwise order, {a, b}
  localparam logic [1:0] CwOrder [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
  // step per {previous ab, current ab}
  localparam int MoveTab [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam int DetentCount = 4;
  localparam int NumPhases = 10;
  localparam int PhaseItems = 165;
  // debounce per phase, negative picks a random value
  localparam int PhaseDeb [NumPhases] = '{40, 0, 65535, 1, -1, 40, -1, 200, -1, 3};
  localparam int PhaseMode [NumPhases] = '{0, 1, 2, 3, 0, 1, 2, 3, 1, 2};
  localparam int SrcIdlePct [4] = '{0, 61, 0, 7};
  localparam int SinkStallPct [4] = '{0, 0, 61, 7};

  typedef struct packed {
    logic [31:0] now_ms;
    logic        back;
    logic        push;
    logic        b;
    logic        a;
  } pin_sample_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [15:0]                  cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [reb_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [reb_pkg::OutDataW-1:0] m_axis_tdata;

  // decoder and debouncer copy
  logic [15:0] debounce_q = reb_pkg::DebounceReset;
  logic        dec_started = 1'b0;
  logic [1:0]  dec_prev_ab = '0;
  int          dec_count = 0;
  logic        push_raw_q = 1'b0;
  logic        push_stable_q = 1'b0;
  logic        back_raw_q = 1'b0;
  logic        back_stable_q = 1'b0;
  logic [31:0] push_since = '0;
  logic [31:0] back_since = '0;

  // pin stimulus state
  int          enc_pos = 0;
  logic        pin_push = 1'b0;
  logic        pin_back = 1'b0;
  logic [31:0] pin_time = '0;
  int          spin_dir = 1;

  reb_pkg::event_e expected_events [$];
  reb_pkg::event_e due_event;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          errors = 0;
  int          samples_sent = 0;
  int          settings_used = 0;
  int          event_tally [5] = '{0, 0, 0, 0, 0};

  rotary_encoder_button_qualifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic reb_pkg::event_e predict_event(pin_sample_t s);
    logic [1:0]      ab;
    logic [31:0]     push_dt;
    logic [31:0]     back_dt;
    reb_pkg::event_e detent;
    ab = {s.a, s.b};
    detent = reb_pkg::EV_NONE;
    if (!dec_started) begin
      dec_prev_ab = ab;
      push_raw_q = s.push;
      push_stable_q = s.push;
      back_raw_q = s.back;
      back_stable_q = s.back;
      push_since = s.now_ms;
      back_since = s.now_ms;
      dec_started = 1'b1;
      return reb_pkg::EV_NONE;
    end
    dec_count += MoveTab[{dec_prev_ab, ab}];
    dec_prev_ab = ab;
    if (dec_count >= DetentCount) begin
      dec_count = 0;
      detent = reb_pkg::EV_CW;
    end else if (dec_count <= -DetentCount) begin
      dec_count = 0;
      detent = reb_pkg::EV_CCW;
    end
    if (s.push != push_raw_q) begin
      push_raw_q = s.push;
      push_since = s.now_ms;
    end
    if (s.back != back_raw_q) begin
      back_raw_q = s.back;
      back_since = s.now_ms;
    end
    // elapsed time wraps modulo 2^32
    push_dt = s.now_ms - push_since;
    back_dt = s.now_ms - back_since;
    if (back_raw_q != back_stable_q && back_dt >= 32'(debounce_q)) begin
      back_stable_q = back_raw_q;
      if (back_stable_q) return reb_pkg::EV_BACK;
    end
    if (push_raw_q != push_stable_q && push_dt >= 32'(debounce_q)) begin
      push_stable_q = push_raw_q;
      if (push_stable_q) return reb_pkg::EV_PUSH;
    end
    return detent;
  endfunction

  task automatic send_pins();
    pin_sample_t s;
    s = '{now_ms: pin_time, back: pin_back, push: pin_push,
          b: CwOrder[enc_pos][0], a: CwOrder[enc_pos][1]};
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, s};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_events.push_back(predict_event(s));
    samples_sent++;
  endtask

  // dir: +1 clockwise, -1 counter-clockwise, 0 hold, 2 illegal double change
  task automatic step_pins(input int dir, input logic [31:0] dt);
    enc_pos = (enc_pos + dir + 4) % 4;
    pin_time += dt;
    send_pins();
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0 && n < 4000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_debounce(input logic [15:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    debounce_q = value;
    settings_used++;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_first_sample();
    enc_pos  = 1;
    pin_push = 1'b0;
    pin_back = 1'b0;
    pin_time = 32'd1000;
    send_pins();
  endtask

  task automatic test_rotation();
    repeat (4) step_pins(1, 32'd1);
    repeat (4) step_pins(-1, 32'd1);
    step_pins(2, 32'd1);
  endtask

  task automatic test_push();
    pin_push = 1'b1;
    step_pins(1, 32'd5);
    step_pins(0, 32'd39);
    step_pins(0, 32'd1);
    // falling stable edge reports nothing
    pin_push = 1'b0;
    step_pins(-1, 32'd10);
    step_pins(0, 32'd40);
  endtask

  task automatic test_back_priority();
    // both buttons and a detent qualify on the same beat
    pin_push = 1'b1;
    pin_back = 1'b1;
    step_pins(1, 32'd100);
    step_pins(1, 32'd20);
    step_pins(1, 32'd10);
    step_pins(1, 32'd10);
    step_pins(0, 32'd1);
  endtask

  task automatic test_time_wrap();
    pin_push = 1'b0;
    pin_back = 1'b0;
    pin_time = 32'hFFFF_FFF0;
    send_pins();
    step_pins(0, 32'd40);
  endtask

  task automatic test_random_phase(input int deb, input int mode);
    int          n;
    int          r;
    int          dmax;
    logic [31:0] dt;
    set_debounce(deb < 0 ? 16'($urandom_range(2, 65534)) : 16'(deb));
    src_idle_pct   = SrcIdlePct[mode];
    sink_stall_pct = SinkStallPct[mode];
    dmax = int'(debounce_q) / 4 + 8;
    for (n = 0; n < PhaseItems; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) spin_dir = -spin_dir;
      if ($urandom_range(0, 99) < 8) pin_push = ~pin_push;
      if ($urandom_range(0, 99) < 8) pin_back = ~pin_back;
      // rare full jumps move every timestamp bit and wrap the clock
      if ($urandom_range(0, 49) == 0) dt = $urandom;
      else dt = $urandom_range(0, dmax);
      if (r < 80) step_pins(spin_dir, dt);
      else if (r < 90) step_pins(0, dt);
      else step_pins(2, dt);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0d",
                 $time, m_axis_tdata[2:0]);
      end else begin
        due_event = expected_events.pop_front();
        event_tally[int'(due_event)]++;
        if (m_axis_tdata[2:0] !== due_event) begin
          errors++;
          $display("%0t: event_res mismatch, expected %0d (%s), actual %0d",
                   $time, due_event, due_event.name(), m_axis_tdata[2:0]);
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int p;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_rotation();
    test_push();
    test_back_priority();
    test_time_wrap();
    for (p = 0; p < NumPhases; p++) begin
      if (p == 5) pin_time = 32'hFFFF_FC00;
      test_random_phase(PhaseDeb[p], PhaseMode[p]);
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      errors += expected_events.size();
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    end
    $display("covered %0d pin samples over %0d debounce settings, 0 and 65535 included",
             samples_sent, settings_used);
    $display("events checked: none %0d, cw %0d, ccw %0d, push %0d, back %0d",
             event_tally[0], event_tally[1], event_tally[2], event_tally[3], event_tally[4]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
